FILE: rtl/rmbp_pkg.sv
// Shared types and constants of the multibulk command parser.
package rmbp_pkg;

	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int CFG_INDEX_W = 2;
	localparam int HARD_LIMIT = 1024;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARG_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ARG_LENGTH = 2'd1;

	localparam logic [7:0] CHAR_STAR = 8'h2A;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ARG_END = 2'd1,
		KIND_ERROR = 2'd2
	} result_kind_t;

	typedef enum logic [1:0] {
		ERR_BAD_COUNT = 2'd0,
		ERR_NO_DOLLAR = 2'd1,
		ERR_BAD_LENGTH = 2'd2,
		ERR_NO_CRLF = 2'd3
	} error_code_t;

	// A stream byte together with the classes the parser tests it against.
	typedef struct packed {
		logic [7:0] raw;
		logic star;
		logic dollar;
		logic cr;
		logic lf;
		logic blank;
		logic plus;
		logic minus;
		logic digit;
		logic [3:0] digit_val;
	} byte_class_t;

endpackage

FILE: rtl/rmbp_queue.sv
// Small first-in first-out queue with registered storage.
module rmbp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input logic [WIDTH-1:0] push_data,
	output logic pop_valid,
	input logic pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CNTW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNTW'(push) - CNTW'(pop);
		end
	end

endmodule

FILE: rtl/rmbp_front.sv
// Front end: takes stream bytes and classifies them for the parser.
module rmbp_front (
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	output logic push_valid,
	input logic push_ready,
	output rmbp_pkg::byte_class_t push_item
);
	import rmbp_pkg::*;

	assign push_valid = in_valid;
	assign in_ready = push_ready;

	always_comb begin
		push_item.raw = in_byte;
		push_item.star = (in_byte == CHAR_STAR);
		push_item.dollar = (in_byte == CHAR_DOLLAR);
		push_item.cr = (in_byte == CHAR_CR);
		push_item.lf = (in_byte == CHAR_LF);
		// Space and the control characters from TAB through CR count as blanks.
		push_item.blank = (in_byte == CHAR_SPACE) ||
			((in_byte >= CHAR_TAB) && (in_byte <= CHAR_CR));
		push_item.plus = (in_byte == CHAR_PLUS);
		push_item.minus = (in_byte == CHAR_MINUS);
		push_item.digit = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
		push_item.digit_val = in_byte[3:0];
	end

endmodule

FILE: rtl/rmbp_back.sv
// Back end: parser state machine and the result output register.
module rmbp_back #(
	parameter int LIMIT_BITS = 11
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input rmbp_pkg::byte_class_t item,
	input logic [((LIMIT_BITS > rmbp_pkg::COUNT_W) ? LIMIT_BITS : rmbp_pkg::COUNT_W)-1:0]
		max_count,
	input logic [((LIMIT_BITS > rmbp_pkg::COUNT_W) ? LIMIT_BITS : rmbp_pkg::COUNT_W)-1:0]
		max_length,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [rmbp_pkg::INDEX_W-1:0] arg_index,
	output logic command_done,
	output logic [rmbp_pkg::COUNT_W-1:0] arg_count,
	output logic [1:0] error_code
);
	import rmbp_pkg::*;

	localparam int NW = LIMIT_BITS;
	localparam int CW = (LIMIT_BITS > COUNT_W) ? LIMIT_BITS : COUNT_W;
	localparam logic [NW-1:0] NUM_MAX = {NW{1'b1}};

	typedef enum logic [3:0] {
		PH_SEEK,
		PH_CNT_LEAD,
		PH_CNT_BODY,
		PH_CNT_CR,
		PH_DOLLAR,
		PH_LEN_LEAD,
		PH_LEN_BODY,
		PH_LEN_CR,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF
	} phase_t;

	phase_t phase_q, nxt_phase;
	logic [COUNT_W-1:0] expected_q, nxt_expected;
	logic [INDEX_W-1:0] cur_q, nxt_cur;
	logic [NW-1:0] num_q, nxt_num;
	logic neg_q, nxt_neg;
	logic closed_q, nxt_closed;
	logic [NW-1:0] left_q, nxt_left;

	logic out_valid_q;
	result_kind_t kind_q, res_kind;
	error_code_t code_q, res_code;
	logic [7:0] data_q;
	logic [INDEX_W-1:0] index_q;
	logic done_q, res_done;
	logic [COUNT_W-1:0] count_q;
	logic res_valid;
	logic take;

	// Number line decoding shared by the count and length lines.
	logic sub_lead, sub_cr, in_count_line, line_end, lead_in, lead_out;
	logic [NW+3:0] prod;
	logic [NW-1:0] fed_num;
	logic fed_neg, fed_closed;
	logic [CW-1:0] lim_count, lim_length, num_ext;
	logic count_ok, length_ok;
	logic [NW-1:0] left_dec;
	logic last_arg;

	assign item_ready = !out_valid_q || out_ready;
	assign take = item_valid && item_ready;

	assign sub_lead = (phase_q == PH_CNT_LEAD) || (phase_q == PH_LEN_LEAD);
	assign sub_cr = (phase_q == PH_CNT_CR) || (phase_q == PH_LEN_CR);
	assign in_count_line = (phase_q == PH_CNT_LEAD) || (phase_q == PH_CNT_BODY) ||
		(phase_q == PH_CNT_CR);
	assign line_end = sub_cr && item.lf;
	// After a lone CR the reader is still in the blanks if nothing closed it.
	assign lead_in = sub_cr ? !closed_q : sub_lead;

	assign prod = ({4'b0000, num_q} << 3) + ({4'b0000, num_q} << 1) +
		{{NW{1'b0}}, item.digit_val};

	always_comb begin
		fed_num = num_q;
		fed_neg = neg_q;
		fed_closed = closed_q;
		lead_out = 1'b0;
		if (!closed_q) begin
			if (lead_in && item.blank) begin
				lead_out = 1'b1;
			end else if (lead_in && (item.plus || item.minus)) begin
				fed_neg = item.minus;
			end else if (item.digit) begin
				fed_num = (prod > {4'b0000, NUM_MAX}) ? NUM_MAX : prod[NW-1:0];
			end else begin
				fed_closed = 1'b1;
			end
		end
	end

	assign lim_count = (max_count > CW'(HARD_LIMIT)) ? CW'(HARD_LIMIT) : max_count;
	assign lim_length = (max_length > CW'(HARD_LIMIT)) ? CW'(HARD_LIMIT) : max_length;
	assign num_ext = CW'(num_q);
	assign count_ok = !neg_q && (num_q != '0) && (num_ext <= lim_count);
	assign length_ok = !neg_q && (num_q != '0) && (num_ext <= lim_length);
	assign left_dec = left_q - 1'b1;
	assign last_arg = ({1'b0, cur_q} + 1'b1) >= expected_q;

	always_comb begin
		nxt_phase = phase_q;
		nxt_expected = expected_q;
		nxt_cur = cur_q;
		nxt_num = num_q;
		nxt_neg = neg_q;
		nxt_closed = closed_q;
		nxt_left = left_q;
		res_valid = 1'b0;
		res_kind = KIND_DATA;
		res_code = ERR_BAD_COUNT;
		res_done = 1'b0;
		unique case (phase_q)
			PH_SEEK: begin
				if (item.star) begin
					nxt_phase = PH_CNT_LEAD;
					nxt_expected = '0;
					nxt_cur = '0;
					nxt_num = '0;
					nxt_neg = 1'b0;
					nxt_closed = 1'b0;
				end
			end
			PH_CNT_LEAD, PH_CNT_BODY, PH_CNT_CR,
			PH_LEN_LEAD, PH_LEN_BODY, PH_LEN_CR: begin
				if (line_end) begin
					if (in_count_line) begin
						if (count_ok) begin
							nxt_expected = COUNT_W'(num_ext);
							nxt_cur = '0;
							nxt_phase = PH_DOLLAR;
						end else begin
							res_valid = 1'b1;
							res_code = ERR_BAD_COUNT;
						end
					end else begin
						if (length_ok) begin
							nxt_left = num_q;
							nxt_phase = PH_DATA;
						end else begin
							res_valid = 1'b1;
							res_code = ERR_BAD_LENGTH;
						end
					end
				end else begin
					nxt_num = fed_num;
					nxt_neg = fed_neg;
					nxt_closed = fed_closed;
					if (item.cr) begin
						nxt_phase = in_count_line ? PH_CNT_CR : PH_LEN_CR;
					end else if (lead_out) begin
						nxt_phase = in_count_line ? PH_CNT_LEAD : PH_LEN_LEAD;
					end else begin
						nxt_phase = in_count_line ? PH_CNT_BODY : PH_LEN_BODY;
					end
				end
			end
			PH_DOLLAR: begin
				if (item.dollar) begin
					nxt_num = '0;
					nxt_neg = 1'b0;
					nxt_closed = 1'b0;
					nxt_phase = PH_LEN_LEAD;
				end else begin
					res_valid = 1'b1;
					res_code = ERR_NO_DOLLAR;
				end
			end
			PH_DATA: begin
				res_valid = 1'b1;
				res_kind = KIND_DATA;
				nxt_left = left_dec;
				if (left_dec == '0) begin
					nxt_phase = PH_DATA_CR;
				end
			end
			PH_DATA_CR: begin
				if (item.cr) begin
					nxt_phase = PH_DATA_LF;
				end else begin
					res_valid = 1'b1;
					res_code = ERR_NO_CRLF;
				end
			end
			PH_DATA_LF: begin
				if (item.lf) begin
					res_valid = 1'b1;
					res_kind = KIND_ARG_END;
					res_done = last_arg;
					if (last_arg) begin
						nxt_expected = '0;
						nxt_cur = '0;
						nxt_phase = PH_SEEK;
					end else begin
						nxt_cur = cur_q + 1'b1;
						nxt_phase = PH_DOLLAR;
					end
				end else begin
					res_valid = 1'b1;
					res_code = ERR_NO_CRLF;
				end
			end
			default: begin
				nxt_phase = PH_SEEK;
			end
		endcase

		// Every fault resynchronizes; a '*' that caused it opens a new command.
		if (res_valid && (res_kind == KIND_DATA) && (phase_q != PH_DATA)) begin
			res_kind = KIND_ERROR;
			nxt_expected = '0;
			nxt_cur = '0;
			if (item.star) begin
				nxt_num = '0;
				nxt_neg = 1'b0;
				nxt_closed = 1'b0;
				nxt_phase = PH_CNT_LEAD;
			end else begin
				nxt_phase = PH_SEEK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			expected_q <= '0;
			cur_q <= '0;
			num_q <= '0;
			neg_q <= 1'b0;
			closed_q <= 1'b0;
			left_q <= '0;
			out_valid_q <= 1'b0;
			kind_q <= KIND_DATA;
			code_q <= ERR_BAD_COUNT;
			data_q <= '0;
			index_q <= '0;
			done_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (take) begin
				phase_q <= nxt_phase;
				expected_q <= nxt_expected;
				cur_q <= nxt_cur;
				num_q <= nxt_num;
				neg_q <= nxt_neg;
				closed_q <= nxt_closed;
				left_q <= nxt_left;
			end
			if (item_ready) begin
				out_valid_q <= take && res_valid;
				kind_q <= res_kind;
				code_q <= (res_kind == KIND_ERROR) ? res_code : ERR_BAD_COUNT;
				data_q <= (res_kind == KIND_DATA) ? item.raw : 8'h00;
				index_q <= cur_q;
				done_q <= res_done;
				count_q <= expected_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign data_byte = data_q;
	assign arg_index = index_q;
	assign command_done = done_q;
	assign arg_count = count_q;
	assign error_code = code_q;

endmodule

FILE: rtl/resp_multibulk_command_parser_unit.sv
// Top level of the multibulk command parser: configuration, front end, queue and back end.
//
// The block parses a client command stream of the form "*<count>CRLF" followed by
// <count> arguments "$<len>CRLF<len bytes>CRLF", one byte item per cycle while not stalled.
// Input channel: in_valid/in_ready with in_byte. Output channel: out_valid/out_ready
// with kind, data_byte, arg_index, command_done, arg_count and error_code.
// Configuration channel: cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; index 0 is max_arg_count, index 1 is max_arg_length, others are ignored.
// Throughput is one byte per cycle while results are taken, set by the back end state
// machine, which handles one queued byte per cycle. A result passes the queue storage and
// then the output register once its byte is accepted.
// When the receiver stalls, the result holds in the output register, the back end
// stops, and the queue (QUEUE_DEPTH items) absorbs bytes until in_ready falls.
// Reset empties the queue and output register, returns the parser to seeking '*',
// and sets both limits to 1024. A protocol fault gives an error item and the
// parser seeks the next '*', or starts a new command at once if the byte was '*'.
module resp_multibulk_command_parser_unit #(
	parameter int LIMIT_BITS = 11,
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [rmbp_pkg::INDEX_W-1:0] arg_index,
	output logic command_done,
	output logic [rmbp_pkg::COUNT_W-1:0] arg_count,
	output logic [1:0] error_code,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [rmbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [LIMIT_BITS-1:0] cfg_data
);
	import rmbp_pkg::*;

	localparam int CW = (LIMIT_BITS > COUNT_W) ? LIMIT_BITS : COUNT_W;

	logic [CW-1:0] max_count_q;
	logic [CW-1:0] max_length_q;
	logic push_valid, push_ready;
	byte_class_t push_item;
	logic pop_valid, pop_ready;
	logic [$bits(byte_class_t)-1:0] pop_bits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= CW'(HARD_LIMIT);
			max_length_q <= CW'(HARD_LIMIT);
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_ARG_COUNT) begin
				max_count_q <= CW'(cfg_data);
			end
			if (cfg_index == REG_MAX_ARG_LENGTH) begin
				max_length_q <= CW'(cfg_data);
			end
		end
	end

	rmbp_front u_front (
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_item(push_item)
	);

	rmbp_queue #(
		.WIDTH($bits(byte_class_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_item),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_bits)
	);

	rmbp_back #(
		.LIMIT_BITS(LIMIT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(pop_valid),
		.item_ready(pop_ready),
		.item(byte_class_t'(pop_bits)),
		.max_count(max_count_q),
		.max_length(max_length_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.arg_index(arg_index),
		.command_done(command_done),
		.arg_count(arg_count),
		.error_code(error_code)
	);

	// A data item never carries an error code or a command end.
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_DATA) |-> (error_code == ERR_BAD_COUNT) && !command_done)
		else $error("data item carries error code or command end");

	// Only an argument end with a known count can close a command.
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_done |-> (kind == KIND_ARG_END) && (arg_count != '0))
		else $error("command end outside an argument end");

	// Non-data items carry a zero data byte.
	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_DATA) |-> (data_byte == 8'h00))
		else $error("non-data item carries a data byte");

	// An argument end always has an index below the accepted count.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ARG_END) |-> ({1'b0, arg_index} < arg_count))
		else $error("argument index beyond the count");

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the multibulk command parser: byte stream stimulus checked against a parser model.
module testbench;
	import rmbp_pkg::*;

	localparam int LIMIT_BITS = 11;
	localparam int unsigned NUM_MAX = (1 << LIMIT_BITS) - 1;
	localparam int NUM_PHASES = 8;
	localparam int RANDOM_BYTES_PER_PHASE = 110;
	localparam int SETTLE_CYCLES = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;
	localparam logic [7:0] CHAR_VT = 8'h0B;
	localparam logic [7:0] CHAR_FF = 8'h0C;

	// The code field reads zero outside error items.
	localparam error_code_t NO_ERROR_CODE = ERR_BAD_COUNT;

	typedef enum logic [2:0] {
		PH_SEEK,
		PH_COUNT,
		PH_DOLLAR,
		PH_LEN,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF
	} parse_phase_t;

	typedef enum logic [1:0] {
		LINE_LEAD,
		LINE_BODY,
		LINE_CR
	} line_part_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0] data;
		logic [INDEX_W-1:0] arg;
		logic done;
		logic [COUNT_W-1:0] count;
		error_code_t code;
	} parse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [INDEX_W-1:0] arg_index;
	logic command_done;
	logic [COUNT_W-1:0] arg_count;
	logic [1:0] error_code;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [LIMIT_BITS-1:0] cfg_data = '0;

	resp_multibulk_command_parser_unit #(.LIMIT_BITS(LIMIT_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.arg_index(arg_index),
		.command_done(command_done),
		.arg_count(arg_count),
		.error_code(error_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	// Parser model state and its copy of the limit registers.
	logic [LIMIT_BITS-1:0] count_limit = LIMIT_BITS'(HARD_LIMIT);
	logic [LIMIT_BITS-1:0] length_limit = LIMIT_BITS'(HARD_LIMIT);
	parse_phase_t parse_phase = PH_SEEK;
	line_part_t line_part = LINE_LEAD;
	logic [COUNT_W-1:0] exp_args = '0;
	logic [INDEX_W-1:0] cur_arg = '0;
	int unsigned num_value = 0;
	bit num_neg = 1'b0;
	bit num_closed = 1'b0;
	int unsigned bytes_left = 0;

	parse_result_t parse_results_q[$];
	logic [7:0] byte_stream[$];
	int unsigned stream_total = 0;
	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	parse_result_t head_result;

	int unsigned count_settings [NUM_PHASES] = '{1024, 4, 1, 0, 2047, 1024, 0, 7};
	int unsigned length_settings [NUM_PHASES] = '{1024, 8, 1, 0, 2047, 3, 0, 16};

	function automatic bit is_blank(input logic [7:0] b);
		return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
	endfunction

	function automatic void clear_number();
		num_value = 0;
		num_neg = 1'b0;
		num_closed = 1'b0;
	endfunction

	// Returns 1 while the reader is still within the leading blanks.
	function automatic bit feed_number(input bit lead, input logic [7:0] b);
		int unsigned v;
		if (num_closed)
			return 1'b0;
		if (lead) begin
			if (is_blank(b))
				return 1'b1;
			if (b == CHAR_PLUS || b == CHAR_MINUS) begin
				num_neg = (b == CHAR_MINUS);
				return 1'b0;
			end
		end
		if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
			v = num_value * 10 + (b - CHAR_ZERO);
			num_value = (v > NUM_MAX) ? NUM_MAX : v;
		end else begin
			num_closed = 1'b1;
		end
		return 1'b0;
	endfunction

	// Returns 1 on the LF that closes a count or length line.
	function automatic bit number_line_byte(input logic [7:0] b);
		bit lead;
		if (line_part == LINE_CR) begin
			if (b == CHAR_LF)
				return 1'b1;
			lead = !num_closed;
		end else begin
			lead = (line_part == LINE_LEAD);
		end
		lead = feed_number(lead, b);
		if (b == CHAR_CR)
			line_part = LINE_CR;
		else
			line_part = lead ? LINE_LEAD : LINE_BODY;
		return 1'b0;
	endfunction

	function automatic bit number_accepted(input logic [LIMIT_BITS-1:0] limit);
		int unsigned lim;
		lim = (limit > HARD_LIMIT) ? HARD_LIMIT : limit;
		return !num_neg && num_value != 0 && num_value <= lim;
	endfunction

	function automatic void start_command();
		exp_args = '0;
		cur_arg = '0;
		clear_number();
		parse_phase = PH_COUNT;
		line_part = LINE_LEAD;
	endfunction

	function automatic parse_result_t make_result(input result_kind_t k, input logic [7:0] d,
			input bit done, input error_code_t c);
		parse_result_t r;
		r.kind = k;
		r.data = d;
		r.arg = cur_arg;
		r.done = done;
		r.count = exp_args;
		r.code = c;
		return r;
	endfunction

	function automatic parse_result_t protocol_fault(input logic [7:0] b, input error_code_t c);
		parse_result_t r;
		r = make_result(KIND_ERROR, 8'h00, 1'b0, c);
		if (b == CHAR_STAR) begin
			start_command();
		end else begin
			exp_args = '0;
			cur_arg = '0;
			parse_phase = PH_SEEK;
		end
		return r;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, output parse_result_t r);
		bit got;
		bit done;
		got = 1'b0;
		r = '0;
		case (parse_phase)
			PH_SEEK: begin
				if (b == CHAR_STAR)
					start_command();
			end
			PH_COUNT: begin
				if (number_line_byte(b)) begin
					if (!number_accepted(count_limit)) begin
						r = protocol_fault(b, ERR_BAD_COUNT);
						got = 1'b1;
					end else begin
						exp_args = COUNT_W'(num_value);
						cur_arg = '0;
						parse_phase = PH_DOLLAR;
					end
				end
			end
			PH_DOLLAR: begin
				if (b != CHAR_DOLLAR) begin
					r = protocol_fault(b, ERR_NO_DOLLAR);
					got = 1'b1;
				end else begin
					clear_number();
					parse_phase = PH_LEN;
					line_part = LINE_LEAD;
				end
			end
			PH_LEN: begin
				if (number_line_byte(b)) begin
					if (!number_accepted(length_limit)) begin
						r = protocol_fault(b, ERR_BAD_LENGTH);
						got = 1'b1;
					end else begin
						bytes_left = num_value;
						parse_phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				r = make_result(KIND_DATA, b, 1'b0, NO_ERROR_CODE);
				got = 1'b1;
				bytes_left = (bytes_left - 1) & NUM_MAX;
				if (bytes_left == 0)
					parse_phase = PH_DATA_CR;
			end
			PH_DATA_CR: begin
				if (b != CHAR_CR) begin
					r = protocol_fault(b, ERR_NO_CRLF);
					got = 1'b1;
				end else begin
					parse_phase = PH_DATA_LF;
				end
			end
			PH_DATA_LF: begin
				if (b != CHAR_LF) begin
					r = protocol_fault(b, ERR_NO_CRLF);
				end else begin
					done = (int'(cur_arg) + 1 >= int'(exp_args));
					r = make_result(KIND_ARG_END, 8'h00, done, NO_ERROR_CODE);
					if (done) begin
						exp_args = '0;
						cur_arg = '0;
						parse_phase = PH_SEEK;
					end else begin
						cur_arg = cur_arg + 1'b1;
						parse_phase = PH_DOLLAR;
					end
				end
				got = 1'b1;
			end
			default: parse_phase = PH_SEEK;
		endcase
		return got;
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		parse_result_t r;
		if (parse_byte(b, r))
			parse_results_q.push_back(r);
	endfunction

	// Byte driver: holds each item until it is taken, then idles at random between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
		end else begin
			if (in_valid && in_ready)
				predict_byte(in_byte);
			if (!in_valid || in_ready) begin
				if (byte_stream.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					in_byte <= byte_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] actual);
		if (actual !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, actual);
			mismatch_count++;
		end
	endtask

	// Result monitor: compares every taken result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (parse_results_q.size() == 0) begin
					$error("result item with no prediction pending");
					mismatch_count++;
				end else begin
					head_result = parse_results_q.pop_front();
					check_field("kind", 16'(head_result.kind), 16'(kind));
					check_field("data_byte", 16'(head_result.data), 16'(data_byte));
					check_field("arg_index", 16'(head_result.arg), 16'(arg_index));
					check_field("command_done", 16'(head_result.done), 16'(command_done));
					check_field("arg_count", 16'(head_result.count), 16'(arg_count));
					check_field("error_code", 16'(head_result.code), 16'(error_code));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [LIMIT_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_MAX_ARG_COUNT)
			count_limit = value;
		else if (idx == REG_MAX_ARG_LENGTH)
			length_limit = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (byte_stream.size() != 0 || in_valid || parse_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_byte(input logic [7:0] b);
		byte_stream.push_back(b);
		stream_total++;
	endfunction

	function automatic void push_crlf();
		push_byte(CHAR_CR);
		push_byte(CHAR_LF);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	function automatic void push_line(input string s);
		push_text(s);
		push_crlf();
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(0, 5))
			0: return CHAR_TAB;
			1: return CHAR_LF;
			2: return CHAR_VT;
			3: return CHAR_FF;
			4: return CHAR_CR;
			default: return CHAR_SPACE;
		endcase
	endfunction

	function automatic int unsigned pick_number(input int unsigned common_max,
			input int unsigned wide_max);
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 0;
		if (k == 1)
			return $urandom_range(1025, 99999);
		if (k == 2)
			return $urandom_range(common_max + 1, wide_max);
		return $urandom_range(1, common_max);
	endfunction

	// Writes a count or length line, now and then with blanks, a sign, a leading zero or junk.
	function automatic void push_number_line(input int unsigned value);
		int k;
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) push_byte(random_blank());
		k = $urandom_range(0, 19);
		if (k == 0)
			push_byte(CHAR_MINUS);
		else if (k == 1)
			push_byte(CHAR_PLUS);
		if ($urandom_range(0, 19) == 0)
			push_byte(CHAR_ZERO);
		push_text($sformatf("%0d", value));
		if ($urandom_range(0, 19) == 0)
			push_byte(8'($urandom_range(0, 255)));
		push_crlf();
	endfunction

	function automatic void push_random_command();
		int unsigned count;
		int unsigned len;
		int unsigned nargs;
		int unsigned sent;
		int k;
		bit cut;
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
		push_byte(CHAR_STAR);
		count = pick_number(4, 12);
		push_number_line(count);
		nargs = (count <= 12) ? count : $urandom_range(0, 3);
		cut = 1'b0;
		for (int a = 0; a < nargs && !cut; a++) begin
			// A command cut short leaves the next star to land where a dollar is due.
			if ($urandom_range(0, 24) == 0) begin
				cut = 1'b1;
			end else begin
				k = $urandom_range(0, 39);
				if (k == 0)
					push_byte(CHAR_STAR);
				else if (k == 1)
					push_byte(8'($urandom_range(0, 255)));
				else
					push_byte(CHAR_DOLLAR);
				len = pick_number(6, 20);
				push_number_line(len);
				sent = (len <= 20) ? len : $urandom_range(0, 2);
				repeat (sent) push_byte(8'($urandom_range(0, 255)));
				k = $urandom_range(0, 29);
				if (k == 0) begin
					push_byte(CHAR_LF);
				end else if (k == 1) begin
					push_byte(CHAR_CR);
					push_byte(8'($urandom_range(0, 255)));
				end else if (k == 2) begin
					push_byte(CHAR_STAR);
				end else begin
					push_crlf();
				end
			end
		end
	endfunction

	function automatic void push_directed();
		push_line("*1");
		push_line("$1");
		push_byte(8'h00);
		push_crlf();
		push_line("*-1");
		push_line("*0");
		push_line("*1");
		push_text("x");
		push_line("*1");
		push_line("$0");
		push_line("*1");
		push_line("$1");
		push_text("ZZ");
		// A star where the dollar belongs both faults and opens the next command.
		push_line("*1");
		push_byte(CHAR_STAR);
		// A CR without LF in the count line is taken as a blank.
		push_byte(CHAR_CR);
		push_line("+2");
		push_line("$1");
		push_byte(8'hFF);
		push_crlf();
		push_line("$2");
		push_text("ab");
		push_crlf();
	endfunction

	// Largest count, then values past the hard limit and saturating digits.
	function automatic void push_limit_commands();
		push_line("*1024");
		repeat (2) begin
			push_line("$1");
			push_byte(8'($urandom_range(0, 255)));
			push_crlf();
		end
		// The star of the next command lands where the third dollar is due.
		push_line("*1025");
		push_line("*99999");
		push_line("*1");
		push_line("$1025");
		push_line("*1024");
		push_byte(CHAR_STAR);
		push_line("1");
		push_line("$99999");
	endfunction

	initial begin
		int unsigned start;
		logic [LIMIT_BITS-1:0] count_value;
		logic [LIMIT_BITS-1:0] length_value;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p != 0) begin
				count_value = LIMIT_BITS'(count_settings[p]);
				length_value = LIMIT_BITS'(length_settings[p]);
				if (p == 6) begin
					count_value = LIMIT_BITS'($urandom_range(1, 1024));
					length_value = LIMIT_BITS'($urandom_range(1, 1024));
				end
				if (p == 3) begin
					write_reg(REG_UNUSED_2, '1);
					write_reg(REG_UNUSED_3, LIMIT_BITS'($urandom_range(0, 2047)));
				end
				write_reg(REG_MAX_ARG_COUNT, count_value);
				write_reg(REG_MAX_ARG_LENGTH, length_value);
			end
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 49;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 49;
				end
				default: begin
					sender_idle_pct = 19;
					receiver_stall_pct = 19;
				end
			endcase
			if (p == 0)
				push_directed();
			if (p == 4)
				push_limit_commands();
			start = stream_total;
			while (stream_total - start < RANDOM_BYTES_PER_PHASE)
				push_random_command();
			wait_idle();
		end
		if (mismatch_count == 0 && parse_results_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
